/* rtl/core/fcde_pkg.sv */
// ----------------------------------------------------------------------------
// fcde_pkg
// Shared types and constants of the foot contact debounce estimator.
// ----------------------------------------------------------------------------
package fcde_pkg;

	localparam int NUM_FEET        = 4;
	localparam int HISTORY_LEN_DEF = 4;

	localparam int FORCE_W = 16;
	localparam int PHASE_W = 16;
	localparam int MASK_W  = NUM_FEET;
	localparam int COUNT_W = 3;

	// register defaults
	localparam logic signed [FORCE_W-1:0] FORCE_THR_RST = 16'sd80;
	localparam logic        [PHASE_W-1:0] PHASE_THR_RST = 16'd45875; // 0.7 in Q0.16

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_THR = 1'b1;
	localparam int CFG_DATA_W = 16;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		OP_UPDATE   = 2'd0,
		OP_LOAD     = 2'd1,
		OP_FLAG_ON  = 2'd2,
		OP_FLAG_OFF = 2'd3
	} op_t;

	localparam int OP_W = 2;

endpackage

/* rtl/core/foot_contact_debounce_estimator_unit.sv */
// ----------------------------------------------------------------------------
// foot_contact_debounce_estimator_unit
// Debounces four foot force readings and tracks rise, stance and control
// contact masks; reports the control masks, the estimate, the contact count and the domain-change flag.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// s_*     | in  | s_tvalid/s_tready   | tuser: op; tdata: force_0..3, phase, desired_mask
// m_*     | out | m_tvalid/m_tready   | tdata: ctrl, ctrl_prev, est, count, change_domain
// cfg_*   | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One transaction in per cycle while s_tready is high; the result is registered
// at acceptance. State is updated at acceptance by one pass of logic; the result
// register decouples the sides, so s_tready drops only while a result is held back.
// cfg_ready is always high. Reset restores all masks, histories and cfg registers.
// ----------------------------------------------------------------------------
module foot_contact_debounce_estimator_unit
	import fcde_pkg::*;
#(
	parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // force_0, force_1, force_2, force_3, phase, desired_mask, pad
	input  logic [OP_W-1:0]        s_tuser,  // op
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // ctrl, ctrl_prev, est, count, change_domain
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic signed [FORCE_W-1:0] force_thr_q;
	logic        [PHASE_W-1:0] phase_thr_q;

	logic [MASK_W-1:0] rise_q, stance_q, control_q, ind_q, ind_prev_q;
	logic              flag_q;
	logic [MASK_W-1:0] rise_n, stance_n, control_n, ind_n, ind_prev_n;
	logic              flag_n;

	logic                   accept;
	op_t                    op;
	logic [PHASE_W-1:0]     phase;
	logic [MASK_W-1:0]      desired;
	logic [MASK_W-1:0]      sample;
	logic [MASK_W-1:0]      est_n;
	logic                   gate;
	logic                   upd_en;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_thr_q <= FORCE_THR_RST;
			phase_thr_q <= PHASE_THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FORCE_THR: force_thr_q <= $signed(cfg_data[FORCE_W-1:0]);
				CFG_PHASE_THR: phase_thr_q <= cfg_data[PHASE_W-1:0];
				default:       ;
			endcase
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);
	assign phase    = s_tdata[4*FORCE_W +: PHASE_W];
	assign desired  = s_tdata[4*FORCE_W+PHASE_W +: MASK_W];
	assign upd_en   = accept && (op == OP_UPDATE);

	for (genvar i = 0; i < NUM_FEET; i++) begin : g_cmp
		assign sample[i] = $signed(s_tdata[i*FORCE_W +: FORCE_W]) > force_thr_q;
	end

	assign gate = phase > phase_thr_q;

	fcde_history #(
		.HISTORY_LEN (HISTORY_LEN)
	) u_history (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_en   (upd_en),
		.sample   (sample),
		.est_next (est_n)
	);

	always_comb begin
		rise_n     = rise_q;
		stance_n   = stance_q;
		control_n  = control_q;
		ind_n      = ind_q;
		ind_prev_n = ind_prev_q;
		flag_n     = flag_q;
		unique case (op)
			OP_UPDATE: begin
				stance_n   = stance_q | (control_q & rise_q);
				rise_n     = rise_q | ~est_n;
				control_n  = (rise_n & est_n & {MASK_W{gate}}) | stance_n;
				ind_prev_n = ind_q;
				ind_n      = control_n;
				flag_n     = &control_n;
			end
			OP_LOAD: begin
				rise_n   = desired;
				stance_n = desired;
				ind_n    = desired;
				flag_n   = 1'b0;
			end
			OP_FLAG_ON:  flag_n = 1'b1;
			OP_FLAG_OFF: flag_n = 1'b0;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q     <= '1;
			stance_q   <= '1;
			control_q  <= '0;
			ind_q      <= '0;
			ind_prev_q <= '0;
			flag_q     <= 1'b0;
		end else if (accept) begin
			rise_q     <= rise_n;
			stance_q   <= stance_n;
			control_q  <= control_n;
			ind_q      <= ind_n;
			ind_prev_q <= ind_prev_n;
			flag_q     <= flag_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {flag_n, COUNT_W'($countones(ind_n)), est_n, ind_prev_n, ind_n};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* rtl/core/fcde_history.sv */
// ----------------------------------------------------------------------------
// fcde_history
// Per-foot contact sample history and all/none debounced estimate.
// ----------------------------------------------------------------------------
module fcde_history
	import fcde_pkg::*;
#(
	parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd_en,
	input  logic [MASK_W-1:0] sample,
	output logic [MASK_W-1:0] est_next
);

	logic [HISTORY_LEN-1:0] hist_q [NUM_FEET];
	logic [HISTORY_LEN-1:0] hist_next [NUM_FEET];
	logic [MASK_W-1:0]      est_q;

	for (genvar i = 0; i < NUM_FEET; i++) begin : g_foot
		if (HISTORY_LEN == 1) begin : g_one
			assign hist_next[i] = sample[i];
		end else begin : g_shift
			assign hist_next[i] = {hist_q[i][HISTORY_LEN-2:0], sample[i]};
		end

		always_comb begin
			est_next[i] = est_q[i];
			if (upd_en) begin
				if (&hist_next[i])
					est_next[i] = 1'b1;
				else if (~|hist_next[i])
					est_next[i] = 1'b0;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hist_q[i] <= '1;
			end else if (upd_en) begin
				hist_q[i] <= hist_next[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '1;
		end else begin
			est_q <= est_next;
		end
	end

endmodule

/* rtl/core/fcde_assert_chk.sv */
// ----------------------------------------------------------------------------
// fcde_assert_chk
// Port-level assertions for the foot contact debounce estimator.
// ----------------------------------------------------------------------------
module fcde_assert_chk
	import fcde_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [OP_W-1:0]        s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// count field always matches the control mask
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:12] == 3'($countones(m_tdata[3:0]))))
		else $error("contact_count does not match contact_ctrl");

	// input stalls only behind a held result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("s_tready low without output backpressure");

	// every accepted transaction yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted transaction gave no result");

	// forcing the flag on shows in the result
	a_flag_on: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == OP_FLAG_ON)) |=> m_tdata[15])
		else $error("change_domain not set after force-on");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind foot_contact_debounce_estimator_unit fcde_assert_chk u_fcde_assert_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
